@@ rtl/skl_pkg.sv @@
package skl_pkg;

    localparam int MAX_K      = 64;
    localparam int VALUE_W    = 32;
    localparam int RANK_W     = 7;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int GROUP      = 8;
    localparam int NUM_GROUPS = (MAX_K + GROUP - 1) / GROUP;
    localparam int CNT_W      = $clog2(MAX_K + 1);
    localparam int IDX_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int EXT_W      = (RANK_W > CNT_W) ? RANK_W : CNT_W;

    localparam logic [ADDR_W-3:0] REG_RANK_K = '0;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic   valid;
        logic   take;
        t_value value;
    } t_link;

    typedef enum logic [1:0] {
        S_RUN,
        S_GATHER,
        S_REDUCE
    } t_state;

endpackage

@@ rtl/skl_cell.sv @@
module skl_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_clear,
    input  logic            i_in_range,
    input  skl_pkg::t_value i_new_value,
    input  skl_pkg::t_link  i_left,
    input  logic            i_right_valid,
    output skl_pkg::t_link  o_link,
    output skl_pkg::t_value o_tail_value
);

    logic            r_valid;
    logic            n_valid;
    skl_pkg::t_value r_value;
    skl_pkg::t_value n_value;
    logic            w_take;

    // The new value belongs at or before this cell when it is larger than the
    // kept value, so equal values stay ahead of it.
    assign w_take = !r_valid || (i_new_value > r_value);

    assign o_link.valid = r_valid;
    assign o_link.take  = w_take;
    assign o_link.value = r_value;

    assign o_tail_value = (r_valid && !i_right_valid) ? r_value : '0;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_clear) begin
            n_valid = 1'b0;
        end else if (i_load) begin
            if (!i_in_range) begin
                n_valid = 1'b0;
            end else if (w_take) begin
                n_value = i_left.take ? i_left.value : i_new_value;
                n_valid = r_valid || i_left.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ rtl/streaming_kth_largest.sv @@
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_value, i_last
// output    out        o_valid / i_stall   o_kth_value, o_short_set
// config    in         APB write / read    paddr, pwdata, prdata
//
// A transaction that does not close a set is taken every cycle; the sorted
// cell row inserts it by a broadcast compare in every cell.
// A transaction with i_last set blocks input through the gather and reduce
// states, while the tail of the row is gathered through a two-level OR tree.
// A held result blocks input only when a new result waits for it in reduce.
// Reset is synchronous and active low; it empties the row and sets k to one.
module streaming_kth_largest (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [31:0]            i_value,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_kth_value,
    output logic                          o_short_set,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [skl_pkg::ADDR_W-1:0]    paddr,
    input  logic [skl_pkg::DATA_W-1:0]    pwdata,
    output logic [skl_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    skl_pkg::t_state                   r_state;
    skl_pkg::t_state                   n_state;
    logic [skl_pkg::RANK_W-1:0]        r_rank;
    logic [skl_pkg::EXT_W-1:0]         w_rank_ext;
    logic [skl_pkg::EXT_W-1:0]         w_k;
    logic [skl_pkg::IDX_W-1:0]         w_k_idx;
    logic                              w_in_accept;
    logic                              w_clear;
    logic                              w_out_free;
    skl_pkg::t_link                    w_link [skl_pkg::MAX_K+1];
    skl_pkg::t_value                   w_tail [skl_pkg::MAX_K];
    logic [skl_pkg::MAX_K-1:0]         w_valid;
    skl_pkg::t_value                   r_part [skl_pkg::NUM_GROUPS];
    skl_pkg::t_value                   n_part [skl_pkg::NUM_GROUPS];
    skl_pkg::t_value                   w_final;
    logic                              r_short;
    logic                              r_out_valid;
    logic                              n_out_valid;
    skl_pkg::t_value                   r_kth_value;
    logic                              r_short_set;
    logic                              w_out_load;

    assign pready = 1'b1;
    assign prdata = (paddr[skl_pkg::ADDR_W-1:2] == skl_pkg::REG_RANK_K)
                  ? skl_pkg::DATA_W'(r_rank) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= skl_pkg::RANK_W'(1);
        end else if (psel && penable && pwrite && pready
                     && paddr[skl_pkg::ADDR_W-1:2] == skl_pkg::REG_RANK_K) begin
            r_rank <= pwdata[skl_pkg::RANK_W-1:0];
        end
    end

    assign w_rank_ext = skl_pkg::EXT_W'(r_rank);

    always_comb begin
        w_k = w_rank_ext;
        if (w_rank_ext == '0) begin
            w_k = skl_pkg::EXT_W'(1);
        end else if (w_rank_ext > skl_pkg::EXT_W'(skl_pkg::MAX_K)) begin
            w_k = skl_pkg::EXT_W'(skl_pkg::MAX_K);
        end
    end

    assign w_k_idx = skl_pkg::IDX_W'(w_k - skl_pkg::EXT_W'(1));

    assign o_stall     = (r_state != skl_pkg::S_RUN);
    assign w_in_accept = i_valid && !o_stall;
    assign w_clear     = (r_state == skl_pkg::S_GATHER);

    assign w_link[0].valid = 1'b1;
    assign w_link[0].take  = 1'b0;
    assign w_link[0].value = '0;

    for (genvar i = 0; i < skl_pkg::MAX_K; i++) begin : g_cell
        logic w_right_valid;
        logic w_in_range;

        if (i == skl_pkg::MAX_K - 1) begin : g_end
            assign w_right_valid = 1'b0;
        end else begin : g_mid
            assign w_right_valid = w_link[i+2].valid;
        end

        assign w_in_range = skl_pkg::EXT_W'(i) < w_k;
        assign w_valid[i] = w_link[i+1].valid;

        skl_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_load        (w_in_accept),
            .i_clear       (w_clear),
            .i_in_range    (w_in_range),
            .i_new_value   (i_value),
            .i_left        (w_link[i]),
            .i_right_valid (w_right_valid),
            .o_link        (w_link[i+1]),
            .o_tail_value  (w_tail[i])
        );
    end

    always_comb begin
        for (int g = 0; g < skl_pkg::NUM_GROUPS; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < skl_pkg::GROUP; j++) begin
                if (g * skl_pkg::GROUP + j < skl_pkg::MAX_K) begin
                    n_part[g] = n_part[g] | w_tail[g * skl_pkg::GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_part  <= n_part;
            r_short <= !w_valid[w_k_idx];
        end
    end

    always_comb begin
        w_final = '0;
        for (int g = 0; g < skl_pkg::NUM_GROUPS; g++) begin
            w_final = w_final | r_part[g];
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_out_load = (r_state == skl_pkg::S_REDUCE) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            skl_pkg::S_RUN: begin
                if (w_in_accept && i_last) begin
                    n_state = skl_pkg::S_GATHER;
                end
            end
            skl_pkg::S_GATHER: begin
                n_state = skl_pkg::S_REDUCE;
            end
            skl_pkg::S_REDUCE: begin
                if (w_out_free) begin
                    n_state = skl_pkg::S_RUN;
                end
            end
            default: begin
                n_state = skl_pkg::S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skl_pkg::S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_kth_value <= w_final;
            r_short_set <= r_short;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kth_value = r_kth_value;
    assign o_short_set = r_short_set;

endmodule

@@ rtl/skl_checker.sv @@
module skl_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       i_last,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [31:0]         o_kth_value,
    input logic                       o_short_set
);

    // A held result transaction keeps its payload until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kth_value) && $stable(o_short_set))
        else $error("held result changed while stalled");

    // Closing a set blocks input through at least the gather and reduce states.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall ##1 o_stall)
        else $error("input taken during gather");

    // An element that does not close a set never blocks the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_last |=> !o_stall)
        else $error("input stalled after an ordinary element");

    // A new result only appears out of the reduce state, while input is stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a closed set");

endmodule

bind streaming_kth_largest skl_checker u_skl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_last      (i_last),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_kth_value (o_kth_value),
    .o_short_set (o_short_set)
);

@@ tb/tb_top.sv @@
module tb_top;

    localparam int   CYCLE_LIMIT = 300000;
    localparam int   ITEM_TARGET = 1150;
    localparam int   CALM_TAIL   = 150;
    localparam int   HOLD_CYCLES = 400;
    localparam int   SETTLE      = 12;

    localparam skl_pkg::t_value VAL_MIN = 32'sh8000_0000;
    localparam skl_pkg::t_value VAL_MAX = 32'sh7FFF_FFFF;

    localparam logic [skl_pkg::ADDR_W-1:0] RANK_ADDR = {skl_pkg::REG_RANK_K, 2'b00};

    typedef struct packed {
        skl_pkg::t_value kth_value;
        logic            short_set;
    } t_kth_result;

    class kth_scoreboard;
        logic [skl_pkg::RANK_W-1:0] rank;
        skl_pkg::t_value            kept[$];
        t_kth_result                expected[$];
        int                         errors;
        int                         checked;
        int                         sets_closed;

        function new();
            rank = skl_pkg::RANK_W'(1);
            errors = 0;
            checked = 0;
            sets_closed = 0;
        endfunction

        function int eff_k();
            int k;
            k = int'(rank);
            if (k == 0) k = 1;
            if (k > skl_pkg::MAX_K) k = skl_pkg::MAX_K;
            return k;
        endfunction

        // Kept values are held largest first; the tail is the k-th largest.
        function void note_item(skl_pkg::t_value v, logic last);
            int k;
            int pos;
            t_kth_result res;
            k = eff_k();
            while (kept.size() > k) void'(kept.pop_back());
            pos = 0;
            while (pos < kept.size() && kept[pos] >= v) pos++;
            if (pos < k) begin
                kept.insert(pos, v);
                if (kept.size() > k) void'(kept.pop_back());
            end
            if (last) begin
                res.kth_value = kept[kept.size() - 1];
                res.short_set = (kept.size() < k);
                expected.push_back(res);
                kept.delete();
                sets_closed++;
            end
        endfunction

        function void check_result(skl_pkg::t_value kth_value, logic short_set);
            t_kth_result want;
            if (expected.size() == 0) begin
                $error("unexpected result: kth_value %0d short_set %0b",
                       kth_value, short_set);
                errors++;
                return;
            end
            want = expected.pop_front();
            checked++;
            if (kth_value !== want.kth_value) begin
                $error("kth_value: expected %0d, actual %0d", want.kth_value, kth_value);
                errors++;
            end
            if (short_set !== want.short_set) begin
                $error("short_set: expected %0b, actual %0b", want.short_set, short_set);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    skl_pkg::t_value              i_value;
    logic                         i_last;
    logic                         o_valid;
    logic                         i_stall;
    skl_pkg::t_value              o_kth_value;
    logic                         o_short_set;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [skl_pkg::ADDR_W-1:0]   paddr;
    logic [skl_pkg::DATA_W-1:0]   pwdata;
    logic [skl_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    kth_scoreboard sb;
    int            cycles;
    int            items_sent;
    int            ranks_written;
    int            cfg_errors;
    bit            idle_on;
    bit            hold_off_req;
    bit            set_open;

    streaming_kth_largest dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kth_value (o_kth_value),
        .o_short_set (o_short_set),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("streaming_kth_largest: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_item(i_value, i_last);
            if (o_valid && !i_stall) sb.check_result(o_kth_value, o_short_set);
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic skl_pkg::t_value gen_value(int mode);
        skl_pkg::t_value v;
        case (mode)
            0: v = $urandom;
            1: begin
                v = $urandom_range(0, 15);
                v = v - 8;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input skl_pkg::t_value v, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        set_open = !last;
    endtask

    task automatic send_set(input int len, input int mode, input bit close);
        for (int i = 0; i < len; i++) send_item(gen_value(mode), close && (i == len - 1));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic config_rank(input int rank);
        logic [skl_pkg::DATA_W-1:0] word;
        logic [skl_pkg::RANK_W-1:0] rank_bits;
        rank_bits = skl_pkg::RANK_W'(rank);
        word = $urandom;
        word[skl_pkg::RANK_W-1:0] = rank_bits;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RANK_ADDR;
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.rank = rank_bits;
        ranks_written++;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== skl_pkg::DATA_W'(rank_bits)) begin
            $error("rank_k readback: expected %0d, actual %0d", rank_bits, prdata);
            cfg_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int rank_choices[10];
        int k;
        int nsets;
        int len;
        int mode;
        int phase;
        bit leave_open;
        bit pressure;

        rank_choices = '{0, 1, 2, 3, 5, 8, 63, 64, 65, 127};
        sb = new();
        cycles = 0;
        items_sent = 0;
        ranks_written = 0;
        cfg_errors = 0;
        idle_on = 1'b1;
        hold_off_req = 1'b0;
        set_open = 1'b0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_last = 1'b0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed sets, starting with the rank left by reset.
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b1);
        send_item(0, 1'b1);
        wait_idle();
        config_rank(0);
        send_item(-1, 1'b0);
        send_item(3, 1'b0);
        send_item(-7, 1'b1);
        wait_idle();
        config_rank(3);
        send_item(10, 1'b0);
        send_item(-5, 1'b1);
        send_item(7, 1'b0);
        send_item(7, 1'b0);
        send_item(7, 1'b0);
        send_item(1, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(0, 1'b1);
        wait_idle();
        config_rank(4);
        for (int i = 9; i >= 5; i--) send_item(i, 1'b0);
        wait_idle();
        config_rank(2);
        send_item(1, 1'b1);
        wait_idle();
        config_rank(127);
        send_item(4, 1'b0);
        send_item(-4, 1'b0);
        send_item(2, 1'b1);
        wait_idle();
        config_rank(64);
        send_item(-3, 1'b1);
        wait_idle();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            pressure = (phase == 6);
            if (items_sent > ITEM_TARGET - CALM_TAIL) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) k = rank_choices[$urandom_range(0, 9)];
            else k = $urandom_range(0, 127);
            config_rank(k);
            if (pressure) hold_off_req = 1'b1;
            nsets = pressure ? 40 : $urandom_range(2, 6);
            for (int s = 0; s < nsets; s++) begin
                if (pressure) len = $urandom_range(1, 3);
                else if (sb.eff_k() > 40 && $urandom_range(0, 3) == 0)
                    len = $urandom_range(60, 70);
                else
                    len = $urandom_range(1, (sb.eff_k() * 2 + 2 > 20) ? 20
                                                                      : sb.eff_k() * 2 + 2);
                mode = $urandom_range(0, 5);
                mode = (mode < 3) ? 0 : (mode < 5) ? 1 : 2;
                leave_open = (s == nsets - 1) && idle_on && !pressure
                             && ($urandom_range(0, 3) == 0);
                send_set(len, mode, !leave_open);
            end
            wait_idle();
        end
        if (set_open) begin
            send_item(gen_value(0), 1'b1);
            wait_idle();
        end

        if (sb.expected.size() != 0)
            $error("%0d expected results never arrived", sb.expected.size());
        $display("Run covered %0d transactions in %0d sets and checked %0d results.",
                 items_sent, sb.sets_closed, sb.checked);
        $display("Rank was written %0d times, including zero, capacity and above.",
                 ranks_written);
        if (sb.errors == 0 && cfg_errors == 0 && sb.expected.size() == 0) begin
            $display("streaming_kth_largest: match");
        end else begin
            $display("streaming_kth_largest: mismatch");
        end
        $finish;
    end

endmodule
